// ----- src/zsu_pkg.sv -----
`timescale 1ns / 1ps
package zsu_pkg;

    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    localparam int N_ELEM = 4;
    localparam int IDX_W  = 2;
    localparam int CNT_W  = 6;
    localparam int KIND_W = 2;

    // request and result kinds
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_CENTER = 2'd0;
    localparam t_kind KIND_COLUMN = 2'd1;
    localparam t_kind KIND_FINISH = 2'd2;
    localparam t_kind KIND_NONE   = 2'd3;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_DOT,
        PH_RESID,
        PH_UPD
    } t_phase;

    // one multiply-accumulate request: x + a*b or x - a*b
    typedef struct packed {
        t_word a;
        t_word b;
        t_word x;
        logic  sub;
    } t_mac_req;

endpackage

// ----- src/zsu_mac.sv -----
`timescale 1ns / 1ps
module zsu_mac import zsu_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  t_mac_req i_req,
    output t_word    o_res
);

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sd2147483648);

    logic signed [PROD_W-1:0] r_prod;
    t_word                    r_x;
    logic                     r_sub;

    logic signed [PROD_W-1:0] w_shift;
    t_word                    w_q;
    logic signed [WORD_W:0]   w_sum;

    // register the full product, addend and operation
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        r_x    <= i_req.x;
        r_sub  <= i_req.sub;
    end

    // floor shift, saturate, add or subtract, saturate
    always_comb begin
        w_shift = r_prod >>> FRAC_BITS;
        if (w_shift > SAT_MAX) begin
            w_q = t_word'(SAT_MAX[WORD_W-1:0]);
        end else if (w_shift < SAT_MIN) begin
            w_q = t_word'(SAT_MIN[WORD_W-1:0]);
        end else begin
            w_q = w_shift[WORD_W-1:0];
        end
        if (r_sub) begin
            w_sum = {r_x[WORD_W-1], r_x} - {w_q[WORD_W-1], w_q};
        end else begin
            w_sum = {r_x[WORD_W-1], r_x} + {w_q[WORD_W-1], w_q};
        end
        if (w_sum[WORD_W] != w_sum[WORD_W-1]) begin
            o_res = w_sum[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            o_res = w_sum[WORD_W-1:0];
        end
    end

endmodule

// ----- src/zsu_ctrl.sv -----
`timescale 1ns / 1ps
module zsu_ctrl import zsu_pkg::*; #(
    parameter int STATE_DIM      = 4,
    parameter int MAX_GENERATORS = 32,
    parameter int FRAC_BITS      = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_kind            i_in_kind,
    input  t_word            i_in_vec [N_ELEM],
    input  t_word            i_in_scalar,
    input  t_word            i_meas [N_ELEM],
    input  t_word            i_gain [N_ELEM],
    output t_mac_req         o_mac_req,
    input  t_word            i_mac_res,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_kind            o_out_kind,
    output t_word            o_out_res [N_ELEM],
    output logic [CNT_W-1:0] o_out_count,
    output logic             o_out_ovf
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_DIM - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_GENERATORS);
    localparam t_word            ONE_Q    = WORD_W'(64'd1 << FRAC_BITS);

    t_state           r_state, n_state;
    t_phase           r_phase;
    logic [IDX_W-1:0] r_idx;
    t_kind            r_kind;
    t_word            r_vec [N_ELEM];
    t_word            r_scalar;
    t_word            r_acc;
    t_word            r_res [N_ELEM];
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;

    logic             w_accept;
    logic             w_load;
    logic             w_last;
    logic [CNT_W-1:0] w_cnt_out;
    logic             w_ovf_out;
    logic [CNT_W-1:0] w_cnt_next;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = (r_idx == LAST_IDX);
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept && i_in_kind != KIND_NONE) n_state = S_ISSUE;
            S_ISSUE: n_state = S_WAIT;
            S_WAIT:  n_state = (r_phase == PH_UPD && w_last) ? S_DONE : S_ISSUE;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // select operands for the shared unit
    always_comb begin
        o_mac_req.a   = i_meas[r_idx];
        o_mac_req.b   = r_vec[r_idx];
        o_mac_req.x   = r_acc;
        o_mac_req.sub = 1'b0;
        case (r_phase)
            PH_RESID: begin
                o_mac_req.a   = r_acc;
                o_mac_req.b   = ONE_Q;
                o_mac_req.x   = r_scalar;
                o_mac_req.sub = 1'b1;
            end
            PH_UPD: begin
                if (r_kind == KIND_FINISH) begin
                    o_mac_req.a = r_scalar;
                    o_mac_req.b = i_gain[r_idx];
                    o_mac_req.x = '0;
                end else begin
                    o_mac_req.a   = i_gain[r_idx];
                    o_mac_req.b   = r_acc;
                    o_mac_req.x   = r_vec[r_idx];
                    o_mac_req.sub = (r_kind == KIND_COLUMN);
                end
            end
            default: ;
        endcase
    end

    // step through dot product, residual and update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DOT;
            r_idx   <= '0;
        end else if (w_accept) begin
            r_phase <= (i_in_kind == KIND_FINISH) ? PH_UPD : PH_DOT;
            r_idx   <= '0;
        end else if (r_state == S_WAIT) begin
            unique case (r_phase)
                PH_DOT: begin
                    if (w_last) begin
                        r_idx   <= '0;
                        r_phase <= (r_kind == KIND_CENTER) ? PH_RESID : PH_UPD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                PH_RESID: r_phase <= PH_UPD;
                PH_UPD:   if (!w_last) r_idx <= r_idx + 1'b1;
                default:  r_phase <= PH_DOT;
            endcase
        end
    end

    // latch the item and collect unit results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_in_kind;
            r_vec    <= i_in_vec;
            r_scalar <= i_in_scalar;
            r_acc    <= '0;
            for (int i = 0; i < N_ELEM; i++) r_res[i] <= '0;
        end else if (r_state == S_WAIT) begin
            if (r_phase == PH_UPD) begin
                r_res[r_idx] <= i_mac_res;
            end else begin
                r_acc <= i_mac_res;
            end
        end
    end

    // generator count and overflow for the finished item
    always_comb begin
        w_cnt_out  = r_count;
        w_ovf_out  = 1'b0;
        w_cnt_next = r_count;
        case (r_kind)
            KIND_COLUMN: begin
                if (r_count < MAX_CNT) begin
                    w_cnt_out = r_count + 1'b1;
                end else begin
                    w_ovf_out = 1'b1;
                end
                w_cnt_next = w_cnt_out;
            end
            KIND_FINISH: begin
                if (r_count < MAX_CNT) begin
                    w_cnt_out = r_count + 1'b1;
                end else begin
                    w_cnt_out = MAX_CNT;
                    w_ovf_out = 1'b1;
                end
                w_cnt_next = '0;
            end
            default: ;
        endcase
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_count     <= w_cnt_next;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_out_kind  <= r_kind;
            o_out_res   <= r_res;
            o_out_count <= w_cnt_out;
            o_out_ovf   <= w_ovf_out;
        end
    end

    assign o_out_valid = r_out_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("generator count above limit");

    a_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ISSUE |=> r_state == S_WAIT)
        else $error("unit result not collected after issue");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_kind != KIND_NONE) |=> r_state == S_ISSUE && r_idx == '0)
        else $error("item accepted but sequence not started");

    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_kind == KIND_FINISH) |=> r_count == '0 && r_out_valid)
        else $error("count not cleared after finish");

endmodule

// ----- src/zonotope_strip_update.sv -----
`timescale 1ns / 1ps
// Items are processed one at a time: a center item takes a dot product, a residual and an
// update, a generator column a dot product and an update, and a finish item only the update.
// Every product goes through one shared multiplier, one multiply-accumulate step at a time.
// The result register lets the next item enter while a result waits to be taken.
// Reset (synchronous, active low) clears the row and gain registers, the count and valids.
module zonotope_strip_update import zsu_pkg::*; #(
    parameter int STATE_DIM      = 4,
    parameter int MAX_GENERATORS = 32,
    parameter int FRAC_BITS      = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [159:0] s_axis_tdata,   // vec_0, vec_1, vec_2, vec_3, scalar_in
    input  logic [1:0]   s_axis_tuser,   // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // out_0, out_1, out_2, out_3, gen_count, overflow, pad
    output logic [1:0]   m_axis_tuser    // item_kind
);

    localparam logic [2:0] REG_GAIN_BASE = 3'd4;

    t_word            r_meas [N_ELEM];
    t_word            r_gain [N_ELEM];
    t_word            w_in_vec [N_ELEM];
    t_word            w_out_res [N_ELEM];
    t_mac_req         w_mac_req;
    t_word            w_mac_res;
    logic [CNT_W-1:0] w_out_count;
    logic             w_out_ovf;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_ELEM; i++) begin
                r_meas[i] <= '0;
                r_gain[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_addr < REG_GAIN_BASE) begin
                r_meas[i_cfg_addr[IDX_W-1:0]] <= i_cfg_data;
            end else begin
                r_gain[i_cfg_addr[IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // unpack and pack the streams
    always_comb begin
        for (int i = 0; i < N_ELEM; i++) begin
            w_in_vec[i] = s_axis_tdata[i*WORD_W +: WORD_W];
        end
    end

    assign m_axis_tdata = {1'b0, w_out_ovf, w_out_count,
                           w_out_res[3], w_out_res[2], w_out_res[1], w_out_res[0]};

    zsu_ctrl #(
        .STATE_DIM      (STATE_DIM),
        .MAX_GENERATORS (MAX_GENERATORS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_kind   (s_axis_tuser),
        .i_in_vec    (w_in_vec),
        .i_in_scalar (s_axis_tdata[159:128]),
        .i_meas      (r_meas),
        .i_gain      (r_gain),
        .o_mac_req   (w_mac_req),
        .i_mac_res   (w_mac_res),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser),
        .o_out_res   (w_out_res),
        .o_out_count (w_out_count),
        .o_out_ovf   (w_out_ovf)
    );

    zsu_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk (i_clk),
        .i_req (w_mac_req),
        .o_res (w_mac_res)
    );

endmodule

// ----- tb/strip_update_check.sv -----
`timescale 1ns / 1ps
module strip_update_check import zsu_pkg::*; #(
    parameter int MAX_GENERATORS = 32,
    parameter int FRAC_BITS      = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [159:0] i_s_tdata,    // vec_0, vec_1, vec_2, vec_3, scalar_in
    input  logic [1:0]   i_s_tuser,    // req_type
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,    // out_0, out_1, out_2, out_3, gen_count, overflow, pad
    input  logic [1:0]   i_m_tuser,    // item_kind
    output int           o_fail_count,
    output int           o_pending
);

    localparam logic [2:0] REG_MEAS_C0 = 3'd0;
    localparam logic [2:0] REG_GAIN_0  = 3'd4;
    localparam int         MAX_PRINTED = 64;

    typedef t_word [N_ELEM-1:0] t_vec;

    typedef struct packed {
        t_kind            kind;
        t_vec             vec;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_strip_result;

    // shadow copy of the row, the gain and the column counter
    t_word            meas_row [N_ELEM];
    t_word            gain_vec [N_ELEM];
    logic [CNT_W-1:0] column_count;
    t_strip_result    expected_results [$];
    int               fail_total = 0;
    int               pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic t_word sat_word(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return t_word'(v);
    endfunction

    // exact product, floor shift, then clamp
    function automatic t_word q_mul(input t_word a, input t_word b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return sat_word(prod >>> FRAC_BITS);
    endfunction

    function automatic t_word sat_sum(input t_word a, input t_word b, input logic negate);
        if (negate)
            return sat_word(longint'(a) - longint'(b));
        return sat_word(longint'(a) + longint'(b));
    endfunction

    // clamp after every product and every addition, element 0 first
    function automatic t_word row_dot(input t_vec v);
        t_word acc;
        acc = '0;
        for (int i = 0; i < N_ELEM; i++)
            acc = sat_sum(acc, q_mul(meas_row[i], v[i]), 1'b0);
        return acc;
    endfunction

    function automatic t_strip_result strip_update(input t_kind kind, input t_vec v,
                                                   input t_word s);
        t_strip_result r;
        t_word         proj;
        r.kind     = kind;
        r.vec      = '0;
        r.count    = column_count;
        r.overflow = 1'b0;
        case (kind)
            KIND_CENTER: begin
                proj = sat_sum(s, row_dot(v), 1'b1);
                for (int i = 0; i < N_ELEM; i++)
                    r.vec[i] = sat_sum(v[i], q_mul(gain_vec[i], proj), 1'b0);
            end
            KIND_COLUMN: begin
                proj = row_dot(v);
                for (int i = 0; i < N_ELEM; i++)
                    r.vec[i] = sat_sum(v[i], q_mul(gain_vec[i], proj), 1'b1);
                if (column_count < MAX_GENERATORS)
                    column_count = column_count + 1'b1;
                else
                    r.overflow = 1'b1;
                r.count = column_count;
            end
            KIND_FINISH: begin
                for (int i = 0; i < N_ELEM; i++)
                    r.vec[i] = q_mul(s, gain_vec[i]);
                if (column_count < MAX_GENERATORS) begin
                    r.count = column_count + 1'b1;
                end else begin
                    r.count    = CNT_W'(MAX_GENERATORS);
                    r.overflow = 1'b1;
                end
                column_count = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (fail_total < MAX_PRINTED)
            $display("%0t: %s got %0d expected %0d", $time, field, got, want);
        fail_total++;
    endtask

    task automatic check_result(input t_strip_result got);
        t_strip_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, item_kind", got.kind, -1);
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("item_kind", got.kind, want.kind);
        for (int i = 0; i < N_ELEM; i++)
            if (got.vec[i] !== want.vec[i])
                report_mismatch($sformatf("out_%0d", i), got.vec[i], want.vec[i]);
        if (got.count !== want.count)
            report_mismatch("gen_count", got.count, want.count);
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
    endtask

    // follow register writes, compare results, then queue predictions
    always @(posedge i_clk) begin
        t_strip_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < N_ELEM; i++) begin
                meas_row[i] = '0;
                gain_vec[i] = '0;
            end
            column_count = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_addr < REG_GAIN_0)
                    meas_row[IDX_W'(i_cfg_addr - REG_MEAS_C0)] = i_cfg_data;
                else
                    gain_vec[IDX_W'(i_cfg_addr - REG_GAIN_0)] = i_cfg_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.kind = i_m_tuser;
                for (int i = 0; i < N_ELEM; i++)
                    got.vec[i] = i_m_tdata[WORD_W*i +: WORD_W];
                got.count    = i_m_tdata[N_ELEM*WORD_W +: CNT_W];
                got.overflow = i_m_tdata[N_ELEM*WORD_W + CNT_W];
                check_result(got);
            end
            // drop the unused request code
            if (i_s_tvalid && i_s_tready && i_s_tuser != KIND_NONE)
                expected_results.push_back(strip_update(i_s_tuser,
                    i_s_tdata[N_ELEM*WORD_W-1:0], i_s_tdata[N_ELEM*WORD_W +: WORD_W]));
        end
        pending_total = expected_results.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench import zsu_pkg::*; ();

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_ITEMS   = 125;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_GEN       = 32;
    localparam int FRAC          = 16;
    localparam int SMALL_SPAN    = 32'h0010_0000;

    localparam logic [2:0] REG_MEAS_C0 = 3'd0;
    localparam logic [2:0] REG_GAIN_0  = 3'd4;

    localparam t_word Q_ONE  = 32'sh0001_0000;
    localparam t_word Q_HALF = 32'sh0000_8000;
    localparam t_word Q_MAX  = 32'sh7fff_ffff;
    localparam t_word Q_MIN  = 32'sh8000_0000;

    typedef t_word [N_ELEM-1:0] t_vec;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic [159:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = KIND_CENTER;
    logic         m_axis_tready = 1'b0;
    logic         o_cfg_ready;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int counted_items = 0;
    int fail_count;
    int pending;

    zonotope_strip_update #(
        .MAX_GENERATORS(MAX_GEN),
        .FRAC_BITS(FRAC)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    strip_update_check #(
        .MAX_GENERATORS(MAX_GEN),
        .FRAC_BITS(FRAC)
    ) check_u (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata),
        .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .i_m_tuser(m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("zonotope_strip_update: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_taken != hold_reqs) begin
            hold_taken    <= hold_reqs;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_vec vec4(input t_word e0, input t_word e1, input t_word e2,
                                  input t_word e3);
        return {e3, e2, e1, e0};
    endfunction

    function automatic t_word rand_small();
        return t_word'($urandom_range(2 * SMALL_SPAN)) - t_word'(SMALL_SPAN);
    endfunction

    // modest values half the time, with extremes and full-range words mixed in
    function automatic t_word rand_q();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3, 4: return t_word'($urandom());
            default: return rand_small();
        endcase
    endfunction

    function automatic t_vec rand_vec();
        return vec4(rand_q(), rand_q(), rand_q(), rand_q());
    endfunction

    // offer one item and hold it until the transaction completes
    task automatic send_item(input t_kind kind, input t_vec v, input t_word s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {s, v};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (kind != KIND_NONE)
            counted_items++;
    endtask

    task automatic send_rand(input t_kind kind);
        send_item(kind, rand_vec(), rand_q());
    endtask

    // one estimator step: center, some columns, then the append
    task automatic send_strip(input int n_cols);
        send_rand(KIND_CENTER);
        repeat (n_cols) send_rand(KIND_COLUMN);
        send_rand(KIND_FINISH);
    endtask

    // stop offering and let the block go quiet
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_regs(input t_vec row, input t_vec gain);
        for (int i = 0; i < 2 * N_ELEM; i++) begin
            i_cfg_valid <= 1'b1;
            if (i < N_ELEM) begin
                i_cfg_addr <= REG_MEAS_C0 + 3'(i);
                i_cfg_data <= row[i];
            end else begin
                i_cfg_addr <= REG_GAIN_0 + 3'(i - N_ELEM);
                i_cfg_data <= gain[i - N_ELEM];
            end
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic phase_regs(input int phase);
        t_vec row;
        t_vec gain;
        case (phase)
            0: begin
                row  = rand_vec();
                gain = rand_vec();
            end
            1: begin
                row  = vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
                gain = vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
            end
            2: begin
                row  = vec4(rand_small(), rand_small(), rand_small(), rand_small());
                gain = vec4(rand_small(), rand_small(), rand_small(), rand_small());
            end
            3: begin
                row  = vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
                gain = vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
            end
            4: begin
                row  = rand_vec();
                gain = vec4(rand_small(), rand_small(), rand_small(), rand_small());
            end
            default: begin
                row  = '0;
                gain = vec4(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
            end
        endcase
        write_regs(row, gain);
    endtask

    initial begin
        int phase_start;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, every request kind, rounding and the ignored code
        write_regs(vec4(Q_ONE, -Q_HALF, 2 * Q_ONE, Q_ONE / 4),
                   vec4(Q_HALF, -Q_ONE, Q_ONE / 8, 3 * Q_ONE));
        send_item(KIND_CENTER, '0, '0);
        send_item(KIND_CENTER, vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), Q_MAX);
        send_item(KIND_CENTER, vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), Q_MIN);
        send_item(KIND_CENTER, vec4(Q_MAX, Q_MIN, Q_MAX, Q_MIN), '0);
        send_item(KIND_CENTER, vec4(32'sd1, -32'sd1, Q_HALF, -3 * Q_HALF), -32'sd1);
        send_item(KIND_COLUMN, '0, rand_q());
        send_item(KIND_COLUMN, vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), Q_MIN);
        send_item(KIND_COLUMN, vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), Q_MAX);
        send_item(KIND_COLUMN, vec4(Q_ONE, -Q_HALF, 32'sd1, -32'sd1), '0);
        send_item(KIND_FINISH, rand_vec(), Q_ONE);
        send_item(KIND_FINISH, rand_vec(), Q_MAX);
        send_item(KIND_FINISH, rand_vec(), Q_MIN);
        send_item(KIND_NONE, rand_vec(), rand_q());
        send_rand(KIND_CENTER);
        send_rand(KIND_COLUMN);
        send_item(KIND_FINISH, rand_vec(), 32'shffff_4000);
        wait_idle();

        // random steps under changing settings and flow control
        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 12;
                recv_idle_pct = 86;
            end else if (phase < 4) begin
                send_idle_pct = 86;
                recv_idle_pct = 12;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            phase_regs(phase);
            if (phase == 4)
                hold_reqs <= hold_reqs + 1;
            phase_start = counted_items;
            send_strip(MAX_GEN + 1);
            while (counted_items - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0)
                    send_rand(t_kind'($urandom_range(3)));
                else if ($urandom_range(7) == 0)
                    send_strip($urandom_range(MAX_GEN + 3, MAX_GEN - 2));
                else
                    send_strip($urandom_range(8));
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("zonotope_strip_update: match");
        else
            $display("zonotope_strip_update: mismatch");
        $finish;
    end

endmodule
